### hw/rtl/lrc_pkg.sv
// Shared types, codes and helpers for the link role contention block.
`timescale 1ns / 1ps
`default_nettype none

package lrc_pkg;

    localparam int CNT_W = 10;
    localparam int DLY_W = 7;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Item kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_BYTE  = 2'd2;

    // Role codes as shown on the outcome field
    localparam logic [1:0] ROLE_MASTER = 2'd0;
    localparam logic [1:0] ROLE_SLAVE  = 2'd1;
    localparam logic [1:0] ROLE_SINGLE = 2'd2;
    localparam logic [1:0] ROLE_NONE   = 2'd3;

    // Bit positions in the early token latch
    localparam int PEND_PING = 0;
    localparam int PEND_ACK  = 1;

    // Configuration register indexes
    localparam logic [2:0] CFG_PING_TOKEN   = 3'd0;
    localparam logic [2:0] CFG_ACK_TOKEN    = 3'd1;
    localparam logic [2:0] CFG_ROUND_LENGTH = 3'd2;
    localparam logic [2:0] CFG_SETTLE       = 3'd3;
    localparam logic [2:0] CFG_RANDOM_WAIT  = 3'd4;
    localparam logic [2:0] CFG_DELAY_OFFSET = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_RANDWAIT,
        PH_LISTEN,
        PH_ACKWAIT,
        PH_DONE
    } lrc_phase_t;

    typedef struct packed {
        logic [7:0]       ping_token;
        logic [7:0]       ack_token;
        logic [CNT_W-1:0] round_length_ms;
        logic [3:0]       settle_ms;
        logic [3:0]       random_wait_ms;
        logic [3:0]       delay_offset_ms;
    } lrc_cfg_t;

    typedef struct packed {
        lrc_phase_t       phase;
        logic [CNT_W-1:0] ms_count;
        logic [DLY_W-1:0] delay_ms;
        logic             forced;
        logic             usb_side;
        logic [1:0]       pending;
        logic [1:0]       role;
    } lrc_state_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] outcome;
        logic       done_res;
    } lrc_result_t;

    // Ack window: round length less the listen delay, floored at zero
    function automatic logic [CNT_W-1:0] window_len(input logic [CNT_W-1:0] rl,
                                                    input logic [DLY_W-1:0] dly);
        logic [CNT_W-1:0] d;
        d = CNT_W'(dly);
        return (rl > d) ? (rl - d) : '0;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/link_role_contention.sv
// Top level of the link role contention block: state, configuration and output buffer.
// Output: a result beat is registered in the main output register, or first in the skid
//   register while the output is stalled.
// Throughput: one input beat per cycle while the skid is empty; in_ready depends only on
//   the skid register, so a beat is still taken while a finished result waits on a stalled output.
// Reset (rst_n low, asynchronous): phase idle, role none, latch empty, registers at defaults.
`timescale 1ns / 1ps
`default_nettype none

module link_role_contention (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input channel
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] kind,
    input  wire logic       skip_delay,
    input  wire logic       has_usb,
    input  wire logic [5:0] random_bits,
    input  wire logic [7:0] rx_byte,
    // output channel
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            tx_valid,
    output logic [7:0]      tx_byte,
    output logic [1:0]      outcome,
    output logic            done_res,
    // configuration writes
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [9:0] cfg_data
);

    lrc_pkg::lrc_cfg_t    cfg_reg;
    lrc_pkg::lrc_state_t  state_reg;
    lrc_pkg::lrc_state_t  state_next;
    lrc_pkg::lrc_result_t res_next;

    // Output buffer: main register drives the port, skid holds a second beat
    logic                 main_valid_reg;
    lrc_pkg::lrc_result_t main_res_reg;
    logic                 skid_valid_reg;
    lrc_pkg::lrc_result_t skid_res_reg;

    logic in_fire;
    logic main_free;

    // ------------------------------------------------------------------
    // Configuration registers: take a write on any edge with cfg_we high,
    // ignore indexes past the last register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ping_token      <= 8'd0;
            cfg_reg.ack_token       <= 8'd1;
            cfg_reg.round_length_ms <= 10'd1000;
            cfg_reg.settle_ms       <= 4'd1;
            cfg_reg.random_wait_ms  <= 4'd2;
            cfg_reg.delay_offset_ms <= 4'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lrc_pkg::CFG_PING_TOKEN:   cfg_reg.ping_token      <= cfg_data[7:0];
                lrc_pkg::CFG_ACK_TOKEN:    cfg_reg.ack_token       <= cfg_data[7:0];
                lrc_pkg::CFG_ROUND_LENGTH: cfg_reg.round_length_ms <= cfg_data;
                lrc_pkg::CFG_SETTLE:       cfg_reg.settle_ms       <= cfg_data[3:0];
                lrc_pkg::CFG_RANDOM_WAIT:  cfg_reg.random_wait_ms  <= cfg_data[3:0];
                lrc_pkg::CFG_DELAY_OFFSET: cfg_reg.delay_offset_ms <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Contention sequencer: one step per accepted beat.
    // ------------------------------------------------------------------
    lrc_step u_step (
        .st           (state_reg),
        .cfg          (cfg_reg),
        .kind         (kind),
        .skip_delay   (skip_delay),
        .has_usb      (has_usb),
        .random_bits  (random_bits),
        .rx_byte      (rx_byte),
        .st_next      (state_next),
        .res          (res_next)
    );

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign main_free = !main_valid_reg || out_ready;

    // Advance the state only on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase    <= lrc_pkg::PH_IDLE;
            state_reg.ms_count <= '0;
            state_reg.delay_ms <= '0;
            state_reg.forced   <= 1'b0;
            state_reg.usb_side <= 1'b0;
            state_reg.pending  <= '0;
            state_reg.role     <= lrc_pkg::ROLE_NONE;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Output buffer control. When the main register frees up, refill it
    // from the skid first so order is kept; otherwise park a new beat in
    // the skid until the consumer takes the main one.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (main_free)
            begin
                if (skid_valid_reg)
                begin
                    main_valid_reg <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    main_valid_reg <= in_fire;
                end
            end
            else if (in_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Payload of the buffer: no reset needed
    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            if (skid_valid_reg)
                main_res_reg <= skid_res_reg;
            else if (in_fire)
                main_res_reg <= res_next;
        end
        else if (in_fire)
        begin
            skid_res_reg <= res_next;
        end
    end

    assign out_valid = main_valid_reg;
    assign tx_valid  = main_res_reg.tx_valid;
    assign tx_byte   = main_res_reg.tx_byte;
    assign outcome   = main_res_reg.outcome;
    assign done_res  = main_res_reg.done_res;

endmodule

`default_nettype wire

### hw/rtl/lrc_step.sv
// Next-state and result logic for one beat of the role contention sequencer.
`timescale 1ns / 1ps
`default_nettype none

module lrc_step (
    input  var lrc_pkg::lrc_state_t  st,
    input  var lrc_pkg::lrc_cfg_t    cfg,
    input  wire logic [1:0]          kind,
    input  wire logic                skip_delay,
    input  wire logic                has_usb,
    input  wire logic [5:0]          random_bits,
    input  wire logic [7:0]          rx_byte,
    output lrc_pkg::lrc_state_t      st_next,
    output lrc_pkg::lrc_result_t     res
);

    logic [lrc_pkg::CNT_W-1:0] cnt_inc;
    logic [lrc_pkg::DLY_W-1:0] rand_dly;
    logic [lrc_pkg::DLY_W-1:0] dly;
    logic [lrc_pkg::CNT_W-1:0] win_ack;
    logic [1:0]                hit;
    logic                      go_listen;
    logic                      go_ack;

    assign cnt_inc  = (st.ms_count == lrc_pkg::CNT_MAX) ? st.ms_count
                                                         : st.ms_count + lrc_pkg::CNT_W'(1);
    assign rand_dly = st.usb_side ? '0
                    : lrc_pkg::DLY_W'(cfg.delay_offset_ms) + lrc_pkg::DLY_W'(random_bits);
    assign hit[lrc_pkg::PEND_PING] = (rx_byte == cfg.ping_token);
    assign hit[lrc_pkg::PEND_ACK]  = (rx_byte == cfg.ack_token);

    always_comb
    begin
        st_next      = st;
        res.tx_valid = 1'b0;
        res.tx_byte  = '0;
        res.done_res = 1'b0;
        go_listen    = 1'b0;
        go_ack       = 1'b0;
        dly          = st.delay_ms;

        unique case (kind)
            lrc_pkg::KIND_START:
            begin
                st_next.phase    = lrc_pkg::PH_SETTLE;
                st_next.ms_count = '0;
                st_next.delay_ms = '0;
                st_next.pending  = '0;
                st_next.forced   = skip_delay;
                st_next.usb_side = has_usb;
            end
            lrc_pkg::KIND_TICK:
            begin
                unique case (st.phase)
                    lrc_pkg::PH_SETTLE:
                    begin
                        if (cnt_inc >= lrc_pkg::CNT_W'(cfg.settle_ms))
                        begin
                            st_next.ms_count = '0;
                            if (st.forced)
                            begin
                                dly       = '0;
                                go_listen = 1'b1;
                            end
                            else if (cfg.random_wait_ms == '0)
                            begin
                                // zero random wait ends on the same tick
                                dly       = rand_dly;
                                go_listen = 1'b1;
                            end
                            else
                            begin
                                st_next.phase = lrc_pkg::PH_RANDWAIT;
                            end
                        end
                        else
                        begin
                            st_next.ms_count = cnt_inc;
                        end
                    end
                    lrc_pkg::PH_RANDWAIT:
                    begin
                        if (cnt_inc >= lrc_pkg::CNT_W'(cfg.random_wait_ms))
                        begin
                            dly       = rand_dly;
                            go_listen = 1'b1;
                        end
                        else
                        begin
                            st_next.ms_count = cnt_inc;
                        end
                    end
                    lrc_pkg::PH_LISTEN:
                    begin
                        if (cnt_inc >= lrc_pkg::CNT_W'(st.delay_ms))
                            go_ack = 1'b1;
                        else
                            st_next.ms_count = cnt_inc;
                    end
                    lrc_pkg::PH_ACKWAIT:
                    begin
                        st_next.ms_count = cnt_inc;
                        if (cnt_inc >= lrc_pkg::window_len(cfg.round_length_ms, st.delay_ms))
                        begin
                            st_next.role  = lrc_pkg::ROLE_SINGLE;
                            st_next.phase = lrc_pkg::PH_DONE;
                            res.done_res  = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            lrc_pkg::KIND_BYTE:
            begin
                unique case (st.phase) inside
                    lrc_pkg::PH_SETTLE, lrc_pkg::PH_RANDWAIT:
                    begin
                        if (st.pending == '0)
                            st_next.pending = hit;
                    end
                    lrc_pkg::PH_LISTEN:
                    begin
                        if (hit[lrc_pkg::PEND_PING])
                        begin
                            res.tx_valid  = 1'b1;
                            res.tx_byte   = cfg.ack_token;
                            st_next.role  = lrc_pkg::ROLE_SLAVE;
                            st_next.phase = lrc_pkg::PH_DONE;
                            res.done_res  = 1'b1;
                        end
                        else if (hit[lrc_pkg::PEND_ACK])
                        begin
                            st_next.phase    = lrc_pkg::PH_SETTLE;
                            st_next.ms_count = '0;
                            st_next.forced   = 1'b0;
                            st_next.pending  = '0;
                        end
                    end
                    lrc_pkg::PH_ACKWAIT:
                    begin
                        if (hit[lrc_pkg::PEND_ACK])
                        begin
                            st_next.role  = lrc_pkg::ROLE_MASTER;
                            st_next.phase = lrc_pkg::PH_DONE;
                            res.done_res  = 1'b1;
                        end
                        else if (hit[lrc_pkg::PEND_PING])
                        begin
                            st_next.phase    = lrc_pkg::PH_SETTLE;
                            st_next.ms_count = '0;
                            st_next.forced   = 1'b0;
                            st_next.pending  = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        // Start listening; a zero delay goes straight to the ping
        if (go_listen)
        begin
            st_next.delay_ms = dly;
            if (dly == '0)
            begin
                go_ack = 1'b1;
            end
            else
            begin
                st_next.phase    = lrc_pkg::PH_LISTEN;
                st_next.ms_count = '0;
                st_next.pending  = '0;
                if (st.pending[lrc_pkg::PEND_PING])
                begin
                    res.tx_valid  = 1'b1;
                    res.tx_byte   = cfg.ack_token;
                    st_next.role  = lrc_pkg::ROLE_SLAVE;
                    st_next.phase = lrc_pkg::PH_DONE;
                    res.done_res  = 1'b1;
                end
                else if (st.pending[lrc_pkg::PEND_ACK])
                begin
                    st_next.phase   = lrc_pkg::PH_SETTLE;
                    st_next.forced  = 1'b0;
                end
            end
        end

        // Send the ping and open the ack window; an empty window ends as single, a latched ack as master
        win_ack = lrc_pkg::window_len(cfg.round_length_ms, dly);
        if (go_ack)
        begin
            st_next.phase    = lrc_pkg::PH_ACKWAIT;
            st_next.ms_count = '0;
            st_next.pending  = '0;
            res.tx_valid     = 1'b1;
            res.tx_byte      = cfg.ping_token;
            if (win_ack == '0)
            begin
                st_next.role  = lrc_pkg::ROLE_SINGLE;
                st_next.phase = lrc_pkg::PH_DONE;
                res.done_res  = 1'b1;
            end
            else if (st.pending[lrc_pkg::PEND_ACK])
            begin
                st_next.role  = lrc_pkg::ROLE_MASTER;
                st_next.phase = lrc_pkg::PH_DONE;
                res.done_res  = 1'b1;
            end
            else if (st.pending[lrc_pkg::PEND_PING])
            begin
                st_next.phase  = lrc_pkg::PH_SETTLE;
                st_next.forced = 1'b0;
            end
        end

        res.outcome = st_next.role;
    end

endmodule

`default_nettype wire

### hw/rtl/lrc_checker.sv
// Port-level checks for the link role contention block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module lrc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       tx_valid,
    input wire logic [7:0] tx_byte,
    input wire logic [1:0] outcome,
    input wire logic       done_res
);

    // A deciding beat always carries a real role
    a_done_has_role: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> outcome != lrc_pkg::ROLE_NONE)
        else $error("decided beat shows no role");

    // No token means a zero byte
    a_idle_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_valid |-> tx_byte == 8'd0)
        else $error("tx_byte set without tx_valid");

    // Becoming slave always answers with an ack
    a_slave_sends_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res && outcome == lrc_pkg::ROLE_SLAVE |-> tx_valid)
        else $error("slave decision without ack");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tx_valid) && $stable(tx_byte)
                                    && $stable(outcome) && $stable(done_res))
        else $error("output beat changed while stalled");

endmodule

bind link_role_contention lrc_checker u_lrc_checker (.*);

`default_nettype wire
